FILE: rtl/bmpq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded min-priority queue.
// Depends on nothing; the top level uses it by scoped names, bmpq_ram does not.

package bmpq_pkg;

    localparam int CAPACITY   = 8;
    localparam int PRICE_BITS = 31;
    localparam int TAG_BITS   = 16;

    // Heap slot index, entry count (holds CAPACITY itself) and child index.
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int CHILD_BITS = IDX_BITS + 2;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic [TAG_BITS-1:0]   tag;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_EXTRACTED = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_EXT_RD,
        S_EXT_CMP,
        S_DN_RD,
        S_DN_CMP
    } state_t;

endpackage

FILE: rtl/bmpq_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one synchronous write port, two read ports with registered data.
// Stands alone; the heap storage of the queue lives here.

module bmpq_ram #(
    parameter int DEPTH     = 8,
    parameter int DATA_BITS = 47
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_BITS-1:0]     wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
    output logic [DATA_BITS-1:0]     rd_a_data,
    input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
    output logic [DATA_BITS-1:0]     rd_b_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

FILE: rtl/bounded_min_priority_queue_top.sv
`timescale 1ns / 1ps
// Top level of the bounded min-priority queue: sequencer and heap datapath.
// Depends on bmpq_pkg and bmpq_ram.
//
//  channel   handshake        payload                                 accepted when
//  command   start / busy     operation, new_price, new_tag           start && !busy
//  result    done (strobe)    status, out_price, out_tag, occupancy   done, one cycle
//
// Every beat of the heap goes through the RAM, whose read data arrives in the cycle
// after the address. An extract on an empty queue answers in the cycle after start.
// An insert into a non-empty queue scans its n entries for a duplicate tag, two slots
// per read beat; unless a duplicate or a full queue ends it, the entry then rises one
// level per read and compare while its parent is higher, until it reaches the root.
// An extract sinks the last entry from the root. A new command waits for busy to fall.
// Reset empties the queue at once; no clearing pass runs. The receiver cannot
// stall: done rises for one cycle, and busy may fall in that same cycle.

module bounded_min_priority_queue_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           operation,
    input  logic [bmpq_pkg::PRICE_BITS-1:0] new_price,
    input  logic [bmpq_pkg::TAG_BITS-1:0]   new_tag,
    output logic                           done,
    output logic [2:0]                     status,
    output logic [bmpq_pkg::PRICE_BITS-1:0] out_price,
    output logic [bmpq_pkg::TAG_BITS-1:0]   out_tag,
    output logic [bmpq_pkg::CNT_BITS-1:0]   occupancy
);

    localparam int IDX_BITS   = bmpq_pkg::IDX_BITS;
    localparam int CNT_BITS   = bmpq_pkg::CNT_BITS;
    localparam int CHILD_BITS = bmpq_pkg::CHILD_BITS;

    // Control state.
    bmpq_pkg::state_t            state_reg, state_next;
    logic [CNT_BITS-1:0]         count_reg, count_next;
    logic [IDX_BITS-1:0]         pos_reg, pos_next;
    logic [CNT_BITS-1:0]         scan_reg, scan_next;
    logic                        dup_reg, dup_next;
    logic                        done_reg, done_next;

    // Payload registers.
    bmpq_pkg::entry_t            item_reg, item_next;
    bmpq_pkg::entry_t            hold_reg, hold_next;
    bmpq_pkg::status_t           status_reg, status_next;
    logic [bmpq_pkg::PRICE_BITS-1:0] out_price_reg, out_price_next;
    logic [bmpq_pkg::TAG_BITS-1:0]   out_tag_reg, out_tag_next;
    logic [CNT_BITS-1:0]         occ_reg, occ_next;

    // RAM ports.
    logic                            wr_en;
    logic [IDX_BITS-1:0]             wr_addr;
    bmpq_pkg::entry_t                wr_data;
    logic [IDX_BITS-1:0]             rd_a_addr, rd_b_addr;
    logic [bmpq_pkg::ENTRY_BITS-1:0] rd_a_data, rd_b_data;
    bmpq_pkg::entry_t                rd_a, rd_b;

    // Shared decisions.
    logic                  accept;
    logic [CHILD_BITS-1:0] child_l, child_r, cnt_ext;
    logic                  take_l, take_r, sift_stop;
    logic [bmpq_pkg::PRICE_BITS-1:0] best_price;
    logic [IDX_BITS-1:0]   best_idx, parent_idx;
    bmpq_pkg::entry_t      best_ent;
    logic                  up_move;
    logic [CNT_BITS:0]     scan_plus1, scan_plus2;
    logic                  hit_a, hit_b, scan_last, dup_now, is_full;

    bmpq_ram #(
        .DEPTH     (bmpq_pkg::CAPACITY),
        .DATA_BITS (bmpq_pkg::ENTRY_BITS)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    assign rd_a   = bmpq_pkg::entry_t'(rd_a_data);
    assign rd_b   = bmpq_pkg::entry_t'(rd_b_data);
    assign accept = start && !busy;

    // Sift-down: the moving entry sits in item_reg while its slot stays a hole.
    assign cnt_ext    = CHILD_BITS'(count_reg);
    assign child_l    = (CHILD_BITS'(pos_reg) << 1) + CHILD_BITS'(1);
    assign child_r    = child_l + CHILD_BITS'(1);
    assign take_l     = (child_l < cnt_ext) && (rd_a.price < item_reg.price);
    assign best_price = take_l ? rd_a.price : item_reg.price;
    assign take_r     = (child_r < cnt_ext) && (rd_b.price < best_price);
    assign sift_stop  = !take_l && !take_r;
    assign best_idx   = take_r ? child_r[IDX_BITS-1:0] : child_l[IDX_BITS-1:0];
    assign best_ent   = take_r ? rd_b : rd_a;

    // Sift-up moves only past a parent with a strictly higher price.
    assign parent_idx = IDX_BITS'((pos_reg - IDX_BITS'(1)) >> 1);
    assign up_move    = item_reg.price < rd_a.price;

    // Duplicate scan covers two slots per read beat.
    assign scan_plus1 = {1'b0, scan_reg} + (CNT_BITS + 1)'(1);
    assign scan_plus2 = {1'b0, scan_reg} + (CNT_BITS + 1)'(2);
    assign hit_a      = (scan_reg < count_reg) && (rd_a.tag == item_reg.tag);
    assign hit_b      = (scan_plus1 < {1'b0, count_reg}) && (rd_b.tag == item_reg.tag);
    assign scan_last  = scan_plus2 >= {1'b0, count_reg};
    assign dup_now    = dup_reg || hit_a || hit_b;
    assign is_full    = count_reg == CNT_BITS'(bmpq_pkg::CAPACITY);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bmpq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == bmpq_pkg::OP_INSERT)
                    begin
                        state_next = (count_reg == '0) ? bmpq_pkg::S_UP_RD
                                                       : bmpq_pkg::S_SCAN_RD;
                    end
                    else if (count_reg != '0)
                    begin
                        state_next = bmpq_pkg::S_EXT_RD;
                    end
                end
            end
            bmpq_pkg::S_SCAN_RD:  state_next = bmpq_pkg::S_SCAN_CMP;
            bmpq_pkg::S_SCAN_CMP:
            begin
                if (!scan_last)
                begin
                    state_next = bmpq_pkg::S_SCAN_RD;
                end
                else if (dup_now || is_full)
                begin
                    state_next = bmpq_pkg::S_IDLE;
                end
                else
                begin
                    state_next = bmpq_pkg::S_UP_RD;
                end
            end
            bmpq_pkg::S_UP_RD:
            begin
                state_next = (pos_reg == '0) ? bmpq_pkg::S_IDLE : bmpq_pkg::S_UP_CMP;
            end
            bmpq_pkg::S_UP_CMP:
            begin
                state_next = up_move ? bmpq_pkg::S_UP_RD : bmpq_pkg::S_IDLE;
            end
            bmpq_pkg::S_EXT_RD:   state_next = bmpq_pkg::S_EXT_CMP;
            bmpq_pkg::S_EXT_CMP:  state_next = bmpq_pkg::S_DN_RD;
            bmpq_pkg::S_DN_RD:    state_next = bmpq_pkg::S_DN_CMP;
            bmpq_pkg::S_DN_CMP:
            begin
                state_next = sift_stop ? bmpq_pkg::S_IDLE : bmpq_pkg::S_DN_RD;
            end
            default:              state_next = bmpq_pkg::S_IDLE;
        endcase
    end

    // Datapath, RAM control and result.
    always_comb
    begin
        count_next     = count_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        dup_next       = dup_reg;
        item_next      = item_reg;
        hold_next      = hold_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        out_price_next = out_price_reg;
        out_tag_next   = out_tag_reg;
        occ_next       = occ_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = item_reg;
        rd_a_addr      = scan_reg[IDX_BITS-1:0];
        rd_b_addr      = scan_plus1[IDX_BITS-1:0];

        unique case (state_reg)
            bmpq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_next.price = new_price;
                    item_next.tag   = new_tag;
                    scan_next       = '0;
                    dup_next        = 1'b0;
                    if (operation == bmpq_pkg::OP_INSERT)
                    begin
                        if (count_reg == '0)
                        begin
                            pos_next   = '0;
                            count_next = CNT_BITS'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next      = 1'b1;
                        status_next    = bmpq_pkg::ST_EMPTY;
                        out_price_next = '0;
                        out_tag_next   = '0;
                        occ_next       = count_reg;
                    end
                end
            end
            bmpq_pkg::S_SCAN_RD:
            begin
                rd_a_addr = scan_reg[IDX_BITS-1:0];
                rd_b_addr = scan_plus1[IDX_BITS-1:0];
            end
            bmpq_pkg::S_SCAN_CMP:
            begin
                dup_next  = dup_now;
                scan_next = scan_plus2[CNT_BITS-1:0];
                if (scan_last)
                begin
                    if (dup_now || is_full)
                    begin
                        done_next      = 1'b1;
                        status_next    = dup_now ? bmpq_pkg::ST_DUPLICATE : bmpq_pkg::ST_FULL;
                        out_price_next = '0;
                        out_tag_next   = '0;
                        occ_next       = count_reg;
                    end
                    else
                    begin
                        pos_next   = count_reg[IDX_BITS-1:0];
                        count_next = count_reg + CNT_BITS'(1);
                    end
                end
            end
            bmpq_pkg::S_UP_RD:
            begin
                rd_a_addr = parent_idx;
                if (pos_reg == '0)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = '0;
                    wr_data        = item_reg;
                    done_next      = 1'b1;
                    status_next    = bmpq_pkg::ST_INSERTED;
                    out_price_next = '0;
                    out_tag_next   = '0;
                    occ_next       = count_reg;
                end
            end
            bmpq_pkg::S_UP_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                if (up_move)
                begin
                    wr_data  = rd_a;
                    pos_next = parent_idx;
                end
                else
                begin
                    wr_data        = item_reg;
                    done_next      = 1'b1;
                    status_next    = bmpq_pkg::ST_INSERTED;
                    out_price_next = '0;
                    out_tag_next   = '0;
                    occ_next       = count_reg;
                end
            end
            bmpq_pkg::S_EXT_RD:
            begin
                rd_a_addr = '0;
                rd_b_addr = IDX_BITS'(count_reg - CNT_BITS'(1));
            end
            bmpq_pkg::S_EXT_CMP:
            begin
                // The root leaves; the last entry becomes the one that sinks from slot 0.
                hold_next  = rd_a;
                item_next  = rd_b;
                count_next = count_reg - CNT_BITS'(1);
                pos_next   = '0;
            end
            bmpq_pkg::S_DN_RD:
            begin
                rd_a_addr = child_l[IDX_BITS-1:0];
                rd_b_addr = child_r[IDX_BITS-1:0];
            end
            bmpq_pkg::S_DN_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                if (sift_stop)
                begin
                    wr_data        = item_reg;
                    done_next      = 1'b1;
                    status_next    = bmpq_pkg::ST_EXTRACTED;
                    out_price_next = hold_reg.price;
                    out_tag_next   = hold_reg.tag;
                    occ_next       = count_reg;
                end
                else
                begin
                    wr_data  = best_ent;
                    pos_next = best_idx;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmpq_pkg::S_IDLE;
            count_reg <= '0;
            pos_reg   <= '0;
            scan_reg  <= '0;
            dup_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            scan_reg  <= scan_next;
            dup_reg   <= dup_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        hold_reg      <= hold_next;
        status_reg    <= status_next;
        out_price_reg <= out_price_next;
        out_tag_reg   <= out_tag_next;
        occ_reg       <= occ_next;
    end

    assign busy      = state_reg != bmpq_pkg::S_IDLE;
    assign done      = done_reg;
    assign status    = status_reg;
    assign out_price = out_price_reg;
    assign out_tag   = out_tag_reg;
    assign occupancy = occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(bmpq_pkg::CAPACITY))
        else $error("entry count exceeds capacity");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("accepted beat neither started work nor finished");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status_reg != bmpq_pkg::ST_EXTRACTED) |-> (out_price == '0 && out_tag == '0))
        else $error("non-extract result carries an entry");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> busy)
        else $error("heap write while idle");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status_reg == bmpq_pkg::ST_INSERTED) |-> (occupancy != '0))
        else $error("insert reported an empty queue");

endmodule
